FILE: sv/iirl_pkg.sv
package iirl_pkg;

  // input operation codes
  localparam logic [2:0] MODE_APPEND      = 3'd0;
  localparam logic [2:0] MODE_INSERT      = 3'd1;
  localparam logic [2:0] MODE_REMOVE_LAST = 3'd2;
  localparam logic [2:0] MODE_REMOVE_AT   = 3'd3;
  localparam logic [2:0] MODE_READ        = 3'd4;
  localparam logic [2:0] MODE_WRITE       = 3'd5;

  // result status codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_BAD  = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  // field widths of a word
  localparam int MODE_BITS   = 3;
  localparam int INDEX_BITS  = 5;
  localparam int HANDLE_W    = 32;
  localparam int COUNT_BITS  = 5;
  localparam int STATUS_BITS = 2;

  // wide enough for any position of the largest list
  localparam int POS_BITS = 8;

  // per-cycle command broadcast along the row of cells
  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_INSERT = 2'd1;
  localparam logic [1:0] CELL_REMOVE = 2'd2;
  localparam logic [1:0] CELL_WRITE  = 2'd3;

  typedef struct packed {
    logic [1:0]          op;
    logic [POS_BITS-1:0] pos;
  } cell_cmd_t;

endpackage

FILE: sv/iirl_cell.sv
module iirl_cell
  import iirl_pkg::*;
#(
  parameter int POS = 0,
  parameter int W   = 32
) (
  input  logic          clk,
  input  cell_cmd_t     cmd,
  input  logic [W-1:0]  handle,
  input  logic [W-1:0]  below,
  input  logic [W-1:0]  above,
  output logic [W-1:0]  data
);

  localparam logic [POS_BITS-1:0] MY_POS = POS_BITS'(POS);

  always_ff @(posedge clk) begin
    case (cmd.op)
      CELL_INSERT: begin
        // target takes the new handle, cells above it move up one place
        if (MY_POS == cmd.pos) begin
          data <= handle;
        end else if (MY_POS > cmd.pos) begin
          data <= below;
        end
      end
      CELL_REMOVE: begin
        // cells from the target up close the gap
        if (MY_POS >= cmd.pos) begin
          data <= above;
        end
      end
      CELL_WRITE: begin
        if (MY_POS == cmd.pos) begin
          data <= handle;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: sv/indexed_insert_remove_list_core.sv
// Ordered list of item handles held in a row of CAPACITY cells, one entry per
// cell. Each input word carries one operation (append, insert at index, remove
// last, remove at index, read, write); every cell decodes the broadcast command
// and either holds, loads the new handle, or takes its lower or upper
// neighbor's entry, so an insert or remove shifts the whole tail at once.
// One word is accepted per cycle and its result word appears on the
// output register the next cycle; the only thing that slows the block is the
// consumer holding m_tready low, since a new word is taken only when the output
// register is empty or being drained. Every input word yields exactly one
// result word: the removed or read handle (zero otherwise), the count after
// the operation, and a status (ok, bad index or empty, full). Indexes past the
// end and unused modes report bad index; append or insert on a full list
// reports full; neither changes the list. Entries need no reset: only
// positions below the count are ever read.
module indexed_insert_remove_list_core
  import iirl_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int HANDLE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // mode[2:0], index[7:3], handle[39:8]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // handle_out[31:0], count[36:32], status[38:37], zero[39]
);

  // stored handle width: input handles are 32 bits, masked to HANDLE_BITS
  localparam int HW   = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IW   = $clog2(CAPACITY);
  localparam int CMPW = (CW > INDEX_BITS) ? CW : INDEX_BITS;
  localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

  // input word fields
  logic [MODE_BITS-1:0]  mode;
  logic [INDEX_BITS-1:0] index;
  logic [HW-1:0]         handle_in;

  assign mode      = s_tdata[MODE_BITS-1:0];
  assign index     = s_tdata[MODE_BITS+INDEX_BITS-1:MODE_BITS];
  assign handle_in = s_tdata[MODE_BITS+INDEX_BITS+HW-1:MODE_BITS+INDEX_BITS];

  // list length and output register
  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;
  logic                   out_valid;
  logic [HANDLE_W-1:0]    out_handle;
  logic [COUNT_BITS-1:0]  out_count;
  logic [STATUS_BITS-1:0] out_status;

  logic accept;
  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // row of cells
  logic [HW-1:0] cell_data [CAPACITY];
  cell_cmd_t     cmd;

  // decode
  logic [CMPW-1:0]  idx_ext;
  logic [CMPW-1:0]  n_ext;
  logic [CMPW-1:0]  pos;
  logic [1:0]       op;
  logic [1:0]       status;
  logic             hit;
  logic [HW-1:0]    rd_data;

  assign idx_ext = CMPW'(index);
  assign n_ext   = CMPW'(count);
  assign rd_data = cell_data[pos[IW-1:0]];

  always_comb begin
    pos        = idx_ext;
    op         = CELL_HOLD;
    status     = STATUS_OK;
    hit        = 1'b0;
    count_next = count;
    unique case (mode) inside
      MODE_APPEND, MODE_INSERT: begin
        if (mode == MODE_APPEND) begin
          pos = n_ext;
        end
        if (pos > n_ext) begin
          status = STATUS_BAD;
        end else if (count == CAP_COUNT) begin
          status = STATUS_FULL;
        end else begin
          op         = CELL_INSERT;
          count_next = count + CW'(1);
        end
      end
      MODE_REMOVE_LAST, MODE_REMOVE_AT: begin
        if (mode == MODE_REMOVE_LAST) begin
          pos = n_ext - CMPW'(1);
        end
        // empty list makes every position out of range
        if (count == '0 || pos >= n_ext) begin
          status = STATUS_BAD;
        end else begin
          op         = CELL_REMOVE;
          hit        = 1'b1;
          count_next = count - CW'(1);
        end
      end
      MODE_READ: begin
        if (pos >= n_ext) begin
          status = STATUS_BAD;
        end else begin
          hit = 1'b1;
        end
      end
      MODE_WRITE: begin
        if (pos >= n_ext) begin
          status = STATUS_BAD;
        end else begin
          op = CELL_WRITE;
        end
      end
      default: begin
        status = STATUS_BAD;
      end
    endcase
  end

  // cells only move when a word is actually taken
  assign cmd.op  = accept ? op : CELL_HOLD;
  assign cmd.pos = POS_BITS'(pos);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [HW-1:0] below;
    logic [HW-1:0] above;
    if (i == 0) begin : g_first
      assign below = '0;
    end else begin : g_mid_lo
      assign below = cell_data[i-1];
    end
    // last cell's upper neighbor is empty space
    if (i == CAPACITY - 1) begin : g_last
      assign above = '0;
    end else begin : g_mid_hi
      assign above = cell_data[i+1];
    end
    iirl_cell #(
      .POS (i),
      .W   (HW)
    ) u_cell (
      .clk    (clk),
      .cmd    (cmd),
      .handle (handle_in),
      .below  (below),
      .above  (above),
      .data   (cell_data[i])
    );
  end

  // list length
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_handle <= hit ? HANDLE_W'(rd_data) : '0;
      out_count  <= COUNT_BITS'(count_next);
      out_status <= status;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_status, out_count, out_handle};

endmodule
